FILE: rtl/mtbc_pkg.sv
// ----------------------------------------------------------------------------
// mtbc_pkg
// Types and constants shared by the markup tag balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mtbc_pkg;

  // field widths
  localparam int TAG_W   = 10;
  localparam int LINE_W  = 16;
  localparam int COL_W   = 12;
  localparam int KIND_W  = 3;
  localparam int CIDX_W  = 3;

  // register reset values
  localparam logic [TAG_W-1:0] CODE_TAG_RST  = 10'd1;
  localparam logic [TAG_W-1:0] CPP_TAG_RST   = 10'd2;
  localparam logic [TAG_W-1:0] PY_TAG_RST    = 10'd3;
  localparam logic [TAG_W-1:0] IMAGE_TAG_RST = 10'd4;
  localparam logic [TAG_W-1:0] LINK_TAG_RST  = 10'd5;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NOT_OPEN = 3'd0,
    KIND_MISMATCH = 3'd1,
    KIND_UNCLOSED = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_DONE     = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_CODE  = 3'd0,
    CFG_CPP   = 3'd1,
    CFG_PY    = 3'd2,
    CFG_IMAGE = 3'd3,
    CFG_LINK  = 3'd4
  } cfg_idx_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // configured tag ids
  typedef struct packed {
    logic [TAG_W-1:0] code_tag;
    logic [TAG_W-1:0] cpp_tag;
    logic [TAG_W-1:0] py_tag;
    logic [TAG_W-1:0] image_tag;
    logic [TAG_W-1:0] link_tag;
  } cfg_t;

  // one stack entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/mtbc_intf.sv
// ----------------------------------------------------------------------------
// mtbc_intf
// Channel interfaces: tag token input, result output, configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtbc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [mtbc_pkg::TAG_W-1:0] tag_id;
  logic                       is_closing;
  logic [mtbc_pkg::LINE_W-1:0] line_number;
  logic [mtbc_pkg::COL_W-1:0] column;

  modport source (output valid, command, tag_id, is_closing, line_number, column,
                  input ready);
  modport sink   (input valid, command, tag_id, is_closing, line_number, column,
                  output ready);
endinterface

interface mtbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtbc_pkg::KIND_W-1:0] error_kind;
  logic [mtbc_pkg::TAG_W-1:0]  error_tag;
  logic [mtbc_pkg::TAG_W-1:0]  expected_tag;
  logic [mtbc_pkg::LINE_W-1:0] error_line;
  logic [mtbc_pkg::COL_W-1:0]  error_column;
  logic                        last;

  modport source (output valid, error_kind, error_tag, expected_tag, error_line,
                  error_column, last, input ready);
  modport sink   (input valid, error_kind, error_tag, expected_tag, error_line,
                  error_column, last, output ready);
endinterface

interface mtbc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mtbc_pkg::CIDX_W-1:0] index;
  logic [mtbc_pkg::TAG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/markup_tag_balance_checker_unit.sv
// ----------------------------------------------------------------------------
// markup_tag_balance_checker_unit
// Stack-based tag matcher: checks tag tokens for balance, with verbatim
// regions and void tags, and reports errors in the order they are found.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      word
//   in_chan   in    valid/ready    command, tag_id, is_closing, line, column
//   out_chan  out   valid/ready    error_kind/tag, expected_tag, line, column, last
//   cfg_chan  in    valid/ready    register index, 10-bit tag id
//
// A tag token is accepted, then decided on the stack top read back from
// the stack RAM through its registered read port.
// An end command is accepted, then drains the stack one entry per result
// word read from the RAM, then sends the done word.
// Reset is synchronous; the stack RAM needs no clearing pass, only entries
// below the count are ever read.
// A result word waits in the output register; the controller stalls only
// when it must produce a new word while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_tag_balance_checker_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mtbc_in_if.sink    in_chan,
  mtbc_out_if.source out_chan,
  mtbc_cfg_if.sink   cfg_chan
);

  localparam int AW = $clog2(STACK_DEPTH);

  mtbc_pkg::cfg_t cfg_r, cfg_nxt;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [mtbc_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  // configuration writes, always taken
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        mtbc_pkg::CFG_CODE:  cfg_nxt.code_tag  = cfg_chan.data;
        mtbc_pkg::CFG_CPP:   cfg_nxt.cpp_tag   = cfg_chan.data;
        mtbc_pkg::CFG_PY:    cfg_nxt.py_tag    = cfg_chan.data;
        mtbc_pkg::CFG_IMAGE: cfg_nxt.image_tag = cfg_chan.data;
        mtbc_pkg::CFG_LINK:  cfg_nxt.link_tag  = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_tag  <= mtbc_pkg::CODE_TAG_RST;
      cfg_r.cpp_tag   <= mtbc_pkg::CPP_TAG_RST;
      cfg_r.py_tag    <= mtbc_pkg::PY_TAG_RST;
      cfg_r.image_tag <= mtbc_pkg::IMAGE_TAG_RST;
      cfg_r.link_tag  <= mtbc_pkg::LINK_TAG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // controller
  mtbc_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_chan),
    .out_ch    (out_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // open-tag stack
  mtbc_ram #(
    .WIDTH (mtbc_pkg::ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/mtbc_ram.sv
// ----------------------------------------------------------------------------
// mtbc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbc_ram #(
  parameter  int WIDTH = 38,
  parameter  int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/mtbc_ctrl.sv
// ----------------------------------------------------------------------------
// mtbc_ctrl
// Stack controller: reads the top entry from the stack RAM, decides push,
// pop or report, walks the stack on an end command and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbc_ctrl #(
  parameter  int STACK_DEPTH = 32,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mtbc_pkg::cfg_t                   cfg,
  mtbc_in_if.sink                               in_ch,
  mtbc_out_if.source                            out_ch,
  output logic                                  ram_we,
  output logic [AW-1:0]                         ram_waddr,
  output logic [mtbc_pkg::ENTRY_W-1:0]          ram_wdata,
  output logic                                  ram_re,
  output logic [AW-1:0]                         ram_raddr,
  input  wire logic [mtbc_pkg::ENTRY_W-1:0]     ram_rdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  mtbc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             in_code_r, in_code_nxt;
  logic             in_cpp_r, in_cpp_nxt;
  logic             in_py_r, in_py_nxt;
  mtbc_pkg::entry_t tok_r, tok_nxt;
  logic             tok_close_r, tok_close_nxt;

  logic                          out_valid_r, out_valid_nxt;
  mtbc_pkg::kind_t               out_kind_r, out_kind_nxt;
  logic [mtbc_pkg::TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic [mtbc_pkg::TAG_W-1:0]    out_exp_r, out_exp_nxt;
  logic [mtbc_pkg::LINE_W-1:0]   out_line_r, out_line_nxt;
  logic [mtbc_pkg::COL_W-1:0]    out_col_r, out_col_nxt;
  logic                          out_last_r, out_last_nxt;

  mtbc_pkg::entry_t top_e;
  logic             in_acc, out_free, hide, is_img, full, empty, match;
  logic             dec_report, dec_go, last_ent;
  logic [CW-1:0]    cnt_dec, cnt_dec2;

  // decode of the current token against the stack top
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign top_e    = mtbc_pkg::entry_t'(ram_rdata);
  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_dec  = cnt_r - CW'(1);
  assign cnt_dec2 = cnt_r - CW'(2);
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign empty    = (cnt_r == '0);
  assign last_ent = (cnt_r == CW'(1));
  assign match    = (top_e.tag == tok_r.tag);
  assign is_img   = (tok_r.tag == cfg.image_tag) || (tok_r.tag == cfg.link_tag);
  assign hide     = (in_cpp_r && (tok_r.tag != cfg.cpp_tag)) ||
                    (in_code_r && (tok_r.tag != cfg.code_tag)) ||
                    (in_py_r && (tok_r.tag != cfg.py_tag));
  assign dec_report = !hide && (tok_close_r ? (empty || !match) : (!is_img && full));
  assign dec_go     = !dec_report || out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command) begin
            state_nxt = empty ? mtbc_pkg::ST_DONE : mtbc_pkg::ST_DRAIN;
          end else begin
            state_nxt = mtbc_pkg::ST_DECIDE;
          end
        end
      end
      mtbc_pkg::ST_DECIDE: begin
        if (dec_go) begin
          state_nxt = mtbc_pkg::ST_IDLE;
        end
      end
      mtbc_pkg::ST_DRAIN: begin
        if (out_free && last_ent) begin
          state_nxt = mtbc_pkg::ST_DONE;
        end
      end
      mtbc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mtbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtbc_pkg::ST_IDLE;
    endcase
  end

  // datapath, RAM access and result word
  always_comb begin
    cnt_nxt       = cnt_r;
    in_code_nxt   = in_code_r;
    in_cpp_nxt    = in_cpp_r;
    in_py_nxt     = in_py_r;
    tok_nxt       = tok_r;
    tok_close_nxt = tok_close_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_exp_nxt   = out_exp_r;
    out_line_nxt  = out_line_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = tok_r;
    ram_re        = 1'b0;
    ram_raddr     = cnt_dec[AW-1:0];
    in_ch.ready   = (state_r == mtbc_pkg::ST_IDLE);
    case (state_r)
      mtbc_pkg::ST_IDLE: begin
        // capture the token and fetch the stack top
        if (in_acc) begin
          tok_nxt.tag   = in_ch.tag_id;
          tok_nxt.line  = in_ch.line_number;
          tok_nxt.col   = in_ch.column;
          tok_close_nxt = in_ch.is_closing;
          ram_re        = !empty;
        end
      end
      mtbc_pkg::ST_DECIDE: begin
        if (dec_go && !hide && !(!tok_close_r && is_img) && !(tok_close_r && empty)) begin
          if (!tok_close_r) begin
            if (full) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = mtbc_pkg::KIND_OVERFLOW;
              out_tag_nxt   = tok_r.tag;
              out_exp_nxt   = '0;
              out_line_nxt  = tok_r.line;
              out_col_nxt   = tok_r.col;
              out_last_nxt  = 1'b1;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (match) begin
            cnt_nxt = cnt_dec;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = mtbc_pkg::KIND_MISMATCH;
            out_tag_nxt   = tok_r.tag;
            out_exp_nxt   = top_e.tag;
            out_line_nxt  = tok_r.line;
            out_col_nxt   = tok_r.col;
            out_last_nxt  = 1'b1;
          end
          // verbatim region toggling
          if (tok_r.tag == cfg.code_tag) begin
            in_code_nxt = !in_code_r;
          end else if (tok_r.tag == cfg.cpp_tag) begin
            in_cpp_nxt = !in_cpp_r;
          end else if (tok_r.tag == cfg.py_tag) begin
            in_py_nxt = !in_py_r;
          end
        end else if (dec_go && !hide && tok_close_r && empty) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mtbc_pkg::KIND_NOT_OPEN;
          out_tag_nxt   = tok_r.tag;
          out_exp_nxt   = '0;
          out_line_nxt  = tok_r.line;
          out_col_nxt   = tok_r.col;
          out_last_nxt  = 1'b1;
        end
      end
      mtbc_pkg::ST_DRAIN: begin
        // report the top entry and fetch the one below
        ram_raddr = cnt_dec2[AW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mtbc_pkg::KIND_UNCLOSED;
          out_tag_nxt   = top_e.tag;
          out_exp_nxt   = '0;
          out_line_nxt  = top_e.line;
          out_col_nxt   = top_e.col;
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_dec;
          ram_re        = !last_ent;
        end
      end
      mtbc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mtbc_pkg::KIND_DONE;
          out_tag_nxt   = '0;
          out_exp_nxt   = '0;
          out_line_nxt  = '0;
          out_col_nxt   = '0;
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          in_code_nxt   = 1'b0;
          in_cpp_nxt    = 1'b0;
          in_py_nxt     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtbc_pkg::ST_IDLE;
      cnt_r       <= '0;
      in_code_r   <= 1'b0;
      in_cpp_r    <= 1'b0;
      in_py_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      in_code_r   <= in_code_nxt;
      in_cpp_r    <= in_cpp_nxt;
      in_py_r     <= in_py_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tok_r       <= tok_nxt;
    tok_close_r <= tok_close_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_exp_r   <= out_exp_nxt;
    out_line_r  <= out_line_nxt;
    out_col_r   <= out_col_nxt;
    out_last_r  <= out_last_nxt;
  end

  // result word
  assign out_ch.valid        = out_valid_r;
  assign out_ch.error_kind   = out_kind_r;
  assign out_ch.error_tag    = out_tag_r;
  assign out_ch.expected_tag = out_exp_r;
  assign out_ch.error_line   = out_line_r;
  assign out_ch.error_column = out_col_r;
  assign out_ch.last         = out_last_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != mtbc_pkg::ST_IDLE)
    else $error("second word taken while one is in work");

  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("stack RAM read and written together");

  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtbc_pkg::ST_DONE) && out_free |=>
      (cnt_r == '0) && !in_code_r && !in_cpp_r && !in_py_r)
    else $error("stack or verbatim flags not cleared at end");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == mtbc_pkg::KIND_DONE) |-> out_last_r)
    else $error("done word without last");

endmodule

`default_nettype wire

FILE: tb/sv/tb_markup_tag_balance_checker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_markup_tag_balance_checker_unit
// Self-checking bench for the markup tag balance checker. Tag and end words
// go in through a bursty sender. A tracker inside the bench keeps its own
// copy of the open-tag stack and the verbatim flags, and it queues the
// reports that each word should cause. A checker pops that queue for every
// result word that the block hands over. The receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_markup_tag_balance_checker_unit;

  localparam int TAG_W          = mtbc_pkg::TAG_W;
  localparam int LINE_W         = mtbc_pkg::LINE_W;
  localparam int COL_W          = mtbc_pkg::COL_W;
  localparam int DEPTH          = 32;
  localparam int IDLE_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam bit CMD_TOKEN      = 1'b0;
  localparam bit CMD_END        = 1'b1;
  localparam bit OPENING        = 1'b0;
  localparam bit CLOSING        = 1'b1;

  typedef struct packed {
    logic              command;
    logic [TAG_W-1:0]  tag;
    logic              closing;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } token_t;

  typedef struct packed {
    mtbc_pkg::kind_t   kind;
    logic [TAG_W-1:0]  tag;
    logic [TAG_W-1:0]  top_tag;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              last;
  } report_t;

  logic clk;
  logic rst_n;

  mtbc_in_if  in_if ();
  mtbc_out_if out_if ();
  mtbc_cfg_if cfg_if ();

  markup_tag_balance_checker_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // tracked block state
  mtbc_pkg::cfg_t   tags_m;
  mtbc_pkg::entry_t open_m [DEPTH];
  int               depth_m;
  bit               code_m, cpp_m, py_m;
  report_t          pending_reports [$];

  int errors;
  int words_sent, active_words, reports_seen, texts_ended;
  int burst_left, gap_max, stall_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sized random field values
  function automatic logic [TAG_W-1:0] rnd_tag();
    return TAG_W'($urandom);
  endfunction

  function automatic logic [LINE_W-1:0] rnd_line();
    return LINE_W'($urandom);
  endfunction

  function automatic logic [COL_W-1:0] rnd_col();
    return COL_W'($urandom);
  endfunction

  function automatic bit rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void expect_report(mtbc_pkg::kind_t kind, logic [TAG_W-1:0] tag,
                                        logic [TAG_W-1:0] top_tag,
                                        logic [LINE_W-1:0] line,
                                        logic [COL_W-1:0] col, logic last);
    report_t r;
    r.kind    = kind;
    r.tag     = tag;
    r.top_tag = top_tag;
    r.line    = line;
    r.col     = col;
    r.last    = last;
    pending_reports.push_back(r);
  endfunction

  // Apply one accepted word to the tracked state and queue its reports.
  // Returns 0 when the word is hidden by a verbatim region or is a void open.
  function automatic bit track_token(token_t t);
    if (t.command == CMD_END) begin
      for (int i = depth_m - 1; i >= 0; i--)
        expect_report(mtbc_pkg::KIND_UNCLOSED, open_m[i].tag, '0, open_m[i].line,
                      open_m[i].col, 1'b0);
      depth_m = 0;
      code_m  = 1'b0;
      cpp_m   = 1'b0;
      py_m    = 1'b0;
      texts_ended++;
      expect_report(mtbc_pkg::KIND_DONE, '0, '0, '0, '0, 1'b1);
      return 1'b1;
    end
    // verbatim regions, cpp first
    if (cpp_m && t.tag != tags_m.cpp_tag) return 1'b0;
    if (code_m && t.tag != tags_m.code_tag) return 1'b0;
    if (py_m && t.tag != tags_m.py_tag) return 1'b0;

    if (t.closing == OPENING) begin
      if (t.tag == tags_m.image_tag || t.tag == tags_m.link_tag) return 1'b0;
      if (depth_m < DEPTH) begin
        open_m[depth_m].tag  = t.tag;
        open_m[depth_m].line = t.line;
        open_m[depth_m].col  = t.col;
        depth_m++;
      end else begin
        expect_report(mtbc_pkg::KIND_OVERFLOW, t.tag, '0, t.line, t.col, 1'b1);
      end
    end else begin
      if (depth_m == 0) begin
        expect_report(mtbc_pkg::KIND_NOT_OPEN, t.tag, '0, t.line, t.col, 1'b1);
        return 1'b1;
      end
      // a mismatch leaves the stack alone
      if (open_m[depth_m-1].tag == t.tag)
        depth_m--;
      else
        expect_report(mtbc_pkg::KIND_MISMATCH, t.tag, open_m[depth_m-1].tag, t.line,
                      t.col, 1'b1);
    end

    if (t.tag == tags_m.code_tag)
      code_m = !code_m;
    else if (t.tag == tags_m.cpp_tag)
      cpp_m = !cpp_m;
    else if (t.tag == tags_m.py_tag)
      py_m = !py_m;
    return 1'b1;
  endfunction

  // Send one word; gaps open only between bursts.
  task automatic send_word(bit cmd, logic [TAG_W-1:0] tag, bit closing,
                           logic [LINE_W-1:0] line, logic [COL_W-1:0] col);
    token_t t;
    int     gap;
    t.command = cmd;
    t.tag     = tag;
    t.closing = closing;
    t.line    = line;
    t.col     = col;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.tag_id      <= tag;
    in_if.is_closing  <= closing;
    in_if.line_number <= line;
    in_if.column      <= col;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    words_sent++;
    if (track_token(t)) active_words++;
  endtask

  // Hold the sender until every queued report has come back.
  task automatic wait_results(int extra);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Write all five tag registers back to back; block must be idle.
  task automatic set_tags(mtbc_pkg::cfg_t c);
    mtbc_pkg::cfg_idx_t idx [5];
    logic [TAG_W-1:0]   val [5];
    idx = '{mtbc_pkg::CFG_CODE, mtbc_pkg::CFG_CPP, mtbc_pkg::CFG_PY,
            mtbc_pkg::CFG_IMAGE, mtbc_pkg::CFG_LINK};
    val = '{c.code_tag, c.cpp_tag, c.py_tag, c.image_tag, c.link_tag};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    tags_m = c;
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 4))
        0:       return tags_m.code_tag;
        1:       return tags_m.cpp_tag;
        2:       return tags_m.py_tag;
        3:       return tags_m.image_tag;
        default: return tags_m.link_tag;
      endcase
    end
    if (r < 85) return TAG_W'(100 + $urandom_range(0, 7));
    return TAG_W'($urandom);
  endfunction

  function automatic mtbc_pkg::cfg_t random_tags();
    mtbc_pkg::cfg_t c;
    c.code_tag  = TAG_W'($urandom_range(0, 15));
    c.cpp_tag   = TAG_W'($urandom_range(0, 15));
    c.py_tag    = TAG_W'($urandom_range(0, 15));
    c.image_tag = TAG_W'($urandom_range(0, 15));
    c.link_tag  = TAG_W'($urandom_range(0, 15));
    return c;
  endfunction

  // Plain nesting, close on empty, mismatch, void tags, end drains
  task automatic test_basic_matching();
    send_word(CMD_TOKEN, '1, CLOSING, '1, '1);
    send_word(CMD_TOKEN, tags_m.code_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd7, OPENING, '0, '0);
    send_word(CMD_TOKEN, 10'd8, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd7, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.image_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.link_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.image_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, '0, OPENING, '1, '0);
    send_word(CMD_TOKEN, 10'd20, OPENING, '0, '1);
    send_word(CMD_TOKEN, '0, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_END, '1, CLOSING, '1, '1);
    send_word(CMD_END, '0, OPENING, '0, '0);
  endtask

  // Hidden tags, region precedence, toggling on a mismatch
  task automatic test_verbatim_regions();
    send_word(CMD_TOKEN, tags_m.code_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd9, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.cpp_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.code_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.cpp_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.code_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.cpp_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.py_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd9, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.py_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd10, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.code_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd10, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.code_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd10, CLOSING, rnd_line(), rnd_col());
    // end clears the region flags
    send_word(CMD_TOKEN, tags_m.code_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_END, rnd_tag(), rnd_bit(), rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd9, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd9, CLOSING, rnd_line(), rnd_col());
  endtask

  // Fill the stack, overflow with and without a region toggle, drain 32
  task automatic test_full_stack();
    for (int i = 0; i < DEPTH; i++)
      send_word(CMD_TOKEN, TAG_W'(100 + (i % 8)), OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd200, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.code_tag, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd201, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, tags_m.code_tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, open_m[depth_m-1].tag, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd202, OPENING, rnd_line(), rnd_col());
    send_word(CMD_END, rnd_tag(), rnd_bit(), rnd_line(), rnd_col());
  endtask

  // Register ids that coincide: void test beats toggling, code beats cpp
  task automatic test_shared_ids();
    mtbc_pkg::cfg_t c;
    wait_results(IDLE_CYCLES);
    c = '{10'd7, 10'd7, 10'd7, 10'd7, 10'd7};
    set_tags(c);
    send_word(CMD_TOKEN, 10'd7, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd7, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd8, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd7, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd8, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd7, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd8, CLOSING, rnd_line(), rnd_col());
    wait_results(IDLE_CYCLES);
    c = '{10'd1023, 10'd1023, 10'd0, 10'd512, 10'd512};
    set_tags(c);
    send_word(CMD_TOKEN, 10'd1023, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd512, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd1023, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd0, OPENING, rnd_line(), rnd_col());
    send_word(CMD_TOKEN, 10'd0, CLOSING, rnd_line(), rnd_col());
    send_word(CMD_END, rnd_tag(), rnd_bit(), rnd_line(), rnd_col());
  endtask

  // One setting of the registers, then mostly well-formed random text
  task automatic run_phase(mtbc_pkg::cfg_t c, int n_words, int close_pct, int gap,
                           int stall);
    int               start;
    int               r;
    logic [TAG_W-1:0] vtag;
    wait_results(IDLE_CYCLES);
    set_tags(c);
    gap_max   = gap;
    stall_pct = stall;
    start     = active_words;
    while (active_words - start < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(CMD_END, rnd_tag(), rnd_bit(), rnd_line(), rnd_col());
      end else if (r < 5) begin
        wait_results(0);
      end else if ((cpp_m || code_m || py_m) && r < 55) begin
        // leave the open verbatim region
        vtag = cpp_m ? tags_m.cpp_tag : (code_m ? tags_m.code_tag : tags_m.py_tag);
        send_word(CMD_TOKEN, vtag, CLOSING, rnd_line(), rnd_col());
      end else if (depth_m > 0 && r < 5 + close_pct) begin
        send_word(CMD_TOKEN, open_m[depth_m-1].tag, CLOSING, rnd_line(), rnd_col());
      end else if (r < 92) begin
        send_word(CMD_TOKEN, pick_tag(), OPENING, rnd_line(), rnd_col());
      end else begin
        // noise: any tag, either direction
        send_word(CMD_TOKEN, rnd_tag(), rnd_bit(), rnd_line(), rnd_col());
      end
    end
    send_word(CMD_END, rnd_tag(), rnd_bit(), rnd_line(), rnd_col());
  endtask

  task automatic test_random_texts();
    mtbc_pkg::cfg_t reset_tags;
    reset_tags = '{mtbc_pkg::CODE_TAG_RST, mtbc_pkg::CPP_TAG_RST, mtbc_pkg::PY_TAG_RST,
                   mtbc_pkg::IMAGE_TAG_RST, mtbc_pkg::LINK_TAG_RST};
    run_phase(reset_tags, 45, 45, 0, 0);
    run_phase('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0}, 35, 40, 3, 20);
    run_phase('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 35, 40, 8, 40);
    run_phase(random_tags(), 55, 20, 2, 10);
    run_phase(random_tags(), 45, 40, 0, 60);
    run_phase(reset_tags, 45, 35, 5, 30);
  endtask

  // receiver: stalls of random length starting at random
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, expected nothing, actual kind %0d tag %0d",
                 $time, out_if.error_kind, out_if.error_tag);
      end else begin
        want = pending_reports.pop_front();
        compare_field("error_kind", 32'(want.kind), 32'(out_if.error_kind));
        compare_field("error_tag", 32'(want.tag), 32'(out_if.error_tag));
        compare_field("expected_tag", 32'(want.top_tag), 32'(out_if.expected_tag));
        compare_field("error_line", 32'(want.line), 32'(out_if.error_line));
        compare_field("error_column", 32'(want.col), 32'(out_if.error_column));
        compare_field("last", 32'(want.last), 32'(out_if.last));
      end
    end
  end

  // watchdog: too long without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // main sequence
  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_TOKEN;
    in_if.tag_id      <= '0;
    in_if.is_closing  <= OPENING;
    in_if.line_number <= '0;
    in_if.column      <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= mtbc_pkg::CFG_CODE;
    cfg_if.data       <= '0;
    errors       = 0;
    words_sent   = 0;
    active_words = 0;
    reports_seen = 0;
    texts_ended  = 0;
    burst_left   = 0;
    gap_max      = 0;
    stall_pct    = 0;
    tags_m  = '{mtbc_pkg::CODE_TAG_RST, mtbc_pkg::CPP_TAG_RST, mtbc_pkg::PY_TAG_RST,
                mtbc_pkg::IMAGE_TAG_RST, mtbc_pkg::LINK_TAG_RST};
    depth_m = 0;
    code_m  = 1'b0;
    cpp_m   = 1'b0;
    py_m    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_matching();
    test_verbatim_regions();
    test_full_stack();
    test_shared_ids();
    test_random_texts();
    wait_results(IDLE_CYCLES);

    $display("Covered %0d words (%0d acted on), %0d end-of-text drains, %0d result words.",
             words_sent, active_words, texts_ended, reports_seen);
    $display("Register settings: reset ids, all zero, all ones, shared and random ids.");
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
